// ===== rtl/dlha_pkg.sv =====
// Shared types, constants and helpers for the drive letter history allocator.
`default_nettype none
package dlha_pkg;

   localparam int LETTER_COUNT      = 26;
   localparam int LETTER_W          = 5;
   localparam int LETTER_SPACE      = 32;
   localparam int LIMIT_W           = 4;
   localparam int COUNT_OUT_W       = 4;
   localparam int HISTORY_DEPTH_DEF = 8;
   localparam int CSR_ADDR_W        = 4;
   localparam int CSR_DATA_W        = 32;
   localparam int REQ_DATA_W        = 168;
   localparam int RSP_DATA_W        = 16;

   typedef enum logic [1:0] {
      CSR_RANGE_FIRST    = 2'd0,
      CSR_RANGE_LAST     = 2'd1,
      CSR_FORBIDDEN_MASK = 2'd2,
      CSR_HISTORY_LIMIT  = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_ASSIGN = 1'b0,
      OP_RECORD = 1'b1
   } op_type;

   typedef enum logic {
      STATUS_OK        = 1'b0,
      STATUS_NO_LETTER = 1'b1
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REMOVE,
      ST_APPEND,
      ST_REPLY
   } back_state_type;

   typedef struct packed {
      logic [15:0] vendor;
      logic [15:0] product;
      logic [15:0] rel;
      logic [7:0]  cfg_num;
      logic [7:0]  iface_num;
      logic [63:0] serial;
      logic [7:0]  otg;
   } unit_key_type;

   typedef struct packed {
      op_type                    op;
      unit_key_type              key;
      logic [LETTER_W-1:0]       mounted;
      logic [LETTER_COUNT-1:0]   avail;
   } item_type;

   typedef struct packed {
      logic [LETTER_W-1:0]     range_first;
      logic [LETTER_W-1:0]     range_last;
      logic [LETTER_COUNT-1:0] forbidden;
      logic [LIMIT_W-1:0]      limit;
   } cfg_type;

   typedef struct packed {
      status_type             status;
      logic [LETTER_W-1:0]    letter;
      logic [COUNT_OUT_W-1:0] count;
   } result_type;

   // Priority encoder: index of the lowest set bit, 0 when none.
   function automatic logic [LETTER_W-1:0] lowest_index(input logic [LETTER_SPACE-1:0] m);
      logic [LETTER_W-1:0] idx;
      idx = '0;
      for (int i = LETTER_SPACE - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = LETTER_W'(i);
         end
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/drive_letter_history_allocator.sv =====
// An assign passes from idle through the history scan, which compares one stored entry per
// clock, to reply; a record also passes through remove and append before reply, and goes
// straight from scan to reply when recording is off.
// The history engine takes one transaction at a time, and the next only once it has left reply;
// a two-entry queue keeps accepting while a result waits.
// Reset: synchronous, active high; clears history count, queue, handshakes, loads register defaults.
`default_nettype none
module drive_letter_history_allocator #(
   parameter int HISTORY_DEPTH = dlha_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [15:0] vendor_id, [31:16] product_id, [47:32] device_release, [55:48] config_number,
   // [63:56] interface_number, [127:64] serial_tag, [135:128] otg_info,
   // [140:136] mounted_letter, [166:141] drives_present, [167] zero
   input  wire logic [dlha_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] operation
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [4:0] drive_letter, [8:5] history_count, [15:9] zero
   output logic [dlha_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   // [0] status
   output logic                                      rsp_tuser,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [dlha_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [dlha_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dlha_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                      csr_pready
);

   dlha_pkg::cfg_type       cfg_ff, cfg_in;
   dlha_pkg::csr_index_type csr_index;
   logic                    csr_write;
   logic                    queue_full;
   logic                    queue_push;
   dlha_pkg::item_type      queue_item;
   logic                    pop_valid;
   logic                    pop;
   dlha_pkg::item_type      pop_item;
   dlha_pkg::result_type    rsp;

   assign csr_pready = 1'b1;
   assign csr_index  = dlha_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            dlha_pkg::CSR_RANGE_FIRST:    cfg_in.range_first = csr_pwdata[4:0];
            dlha_pkg::CSR_RANGE_LAST:     cfg_in.range_last  = csr_pwdata[4:0];
            dlha_pkg::CSR_FORBIDDEN_MASK: cfg_in.forbidden   = csr_pwdata[25:0];
            dlha_pkg::CSR_HISTORY_LIMIT:  cfg_in.limit       = csr_pwdata[3:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         dlha_pkg::CSR_RANGE_FIRST:    csr_prdata = 32'(cfg_ff.range_first);
         dlha_pkg::CSR_RANGE_LAST:     csr_prdata = 32'(cfg_ff.range_last);
         dlha_pkg::CSR_FORBIDDEN_MASK: csr_prdata = 32'(cfg_ff.forbidden);
         dlha_pkg::CSR_HISTORY_LIMIT:  csr_prdata = 32'(cfg_ff.limit);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_first <= 5'd0;
         cfg_ff.range_last  <= 5'd25;
         cfg_ff.forbidden   <= '0;
         cfg_ff.limit       <= 4'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dlha_front u_front (
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_item (queue_item)
   );

   dlha_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (queue_item),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_item  (pop_item)
   );

   dlha_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (pop_valid),
      .in_item       (pop_item),
      .in_pop        (pop),
      .history_limit (cfg_ff.limit),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp           (rsp)
   );

   assign rsp_tdata = {7'b0, rsp.count, rsp.letter};
   assign rsp_tuser = rsp.status;

endmodule
`default_nettype wire

// ===== rtl/dlha_front.sv =====
// Front end: unpacks an incoming transaction and works out the letters available to it.
`default_nettype none
module dlha_front (
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [dlha_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                req_tuser,
   input  wire dlha_pkg::cfg_type                   cfg,
   input  wire logic                                queue_full,
   output logic                                     queue_push,
   output dlha_pkg::item_type                       queue_item
);

   logic [dlha_pkg::LETTER_COUNT-1:0] range_mask;
   logic [dlha_pkg::LETTER_COUNT-1:0] present;

   assign present    = req_tdata[166:141];
   assign req_tready = !queue_full && !reset;
   assign queue_push = req_tvalid && req_tready;

   always_comb begin
      for (int i = 0; i < dlha_pkg::LETTER_COUNT; i++) begin
         range_mask[i] = (dlha_pkg::LETTER_W'(i) >= cfg.range_first) &&
                         (dlha_pkg::LETTER_W'(i) <= cfg.range_last);
      end
   end

   always_comb begin
      queue_item.op            = dlha_pkg::op_type'(req_tuser);
      queue_item.key.vendor    = req_tdata[15:0];
      queue_item.key.product   = req_tdata[31:16];
      queue_item.key.rel       = req_tdata[47:32];
      queue_item.key.cfg_num   = req_tdata[55:48];
      queue_item.key.iface_num = req_tdata[63:56];
      queue_item.key.serial    = req_tdata[127:64];
      queue_item.key.otg       = req_tdata[135:128];
      queue_item.mounted       = req_tdata[140:136];
      queue_item.avail         = range_mask & ~cfg.forbidden & ~present;
   end

endmodule
`default_nettype wire

// ===== rtl/dlha_queue.sv =====
// Two-entry queue between the front end and the history engine.
`default_nettype none
module dlha_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire dlha_pkg::item_type  push_item,
   output logic                     full,
   output logic                     pop_valid,
   input  wire logic                pop,
   output dlha_pkg::item_type       pop_item
);

   dlha_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_pop;

   assign full      = fill_ff == 2'd2;
   assign pop_valid = fill_ff != 2'd0;
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/dlha_back.sv =====
// History engine: scans the history one entry a cycle, updates it and forms the result.
`default_nettype none
module dlha_back #(
   parameter int HISTORY_DEPTH = dlha_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire dlha_pkg::item_type            in_item,
   output logic                               in_pop,
   input  wire logic [dlha_pkg::LIMIT_W-1:0]  history_limit,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output dlha_pkg::result_type               rsp
);

   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CAP_W = (CNT_W > dlha_pkg::LIMIT_W) ? CNT_W : dlha_pkg::LIMIT_W;

   dlha_pkg::unit_key_type           key_ff    [HISTORY_DEPTH];
   logic [dlha_pkg::LETTER_W-1:0]    letter_ff [HISTORY_DEPTH];

   dlha_pkg::back_state_type         state_ff, state_in;
   dlha_pkg::item_type               item_ff, item_in;
   logic [CNT_W-1:0]                 idx_ff, idx_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [dlha_pkg::LETTER_SPACE-1:0] used_ff, used_in;
   logic                             hit_ff, hit_in;
   logic [IDX_W-1:0]                 hit_idx_ff, hit_idx_in;
   logic [dlha_pkg::LETTER_W-1:0]    hit_letter_ff, hit_letter_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   dlha_pkg::result_type             rsp_ff, rsp_in;

   logic [CAP_W-1:0]                 cap;
   logic [CAP_W-1:0]                 limit_ext;
   logic [CAP_W-1:0]                 depth_ext;
   logic [IDX_W-1:0]                 scan_idx;
   logic                             match;
   logic                             do_remove;
   logic [IDX_W-1:0]                 remove_idx;
   logic                             do_append;
   logic [dlha_pkg::LETTER_SPACE-1:0] avail_wide;
   logic [dlha_pkg::LETTER_SPACE-1:0] free_unused;
   dlha_pkg::result_type             assign_result;

   assign limit_ext = CAP_W'(history_limit);
   assign depth_ext = CAP_W'(HISTORY_DEPTH);
   assign cap       = (limit_ext > depth_ext) ? depth_ext : limit_ext;
   assign scan_idx  = idx_ff[IDX_W-1:0];
   assign match     = key_ff[scan_idx] == item_ff.key;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Assign answer from the scan summary.
   always_comb begin
      avail_wide  = dlha_pkg::LETTER_SPACE'(item_ff.avail);
      free_unused = avail_wide & ~used_ff;
      assign_result.count = dlha_pkg::COUNT_OUT_W'(count_ff);
      if (avail_wide == '0) begin
         assign_result.status = dlha_pkg::STATUS_NO_LETTER;
         assign_result.letter = '0;
      end else begin
         assign_result.status = dlha_pkg::STATUS_OK;
         if (hit_ff && avail_wide[hit_letter_ff]) begin
            assign_result.letter = hit_letter_ff;
         end else if (free_unused != '0) begin
            assign_result.letter = dlha_pkg::lowest_index(free_unused);
         end else begin
            assign_result.letter = dlha_pkg::lowest_index(avail_wide);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_letter_in = hit_letter_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      in_pop        = 1'b0;
      do_remove     = 1'b0;
      remove_idx    = hit_ff ? hit_idx_ff : '0;
      do_append     = 1'b0;

      case (state_ff)
         dlha_pkg::ST_IDLE: begin
            if (in_valid) begin
               in_pop   = 1'b1;
               item_in  = in_item;
               idx_in   = '0;
               used_in  = '0;
               hit_in   = 1'b0;
               state_in = dlha_pkg::ST_SCAN;
            end
         end
         dlha_pkg::ST_SCAN: begin
            if (item_ff.op == dlha_pkg::OP_RECORD && cap == '0) begin
               // Recording disabled: history untouched.
               state_in = dlha_pkg::ST_REPLY;
            end else if (idx_ff == count_ff) begin
               state_in = (item_ff.op == dlha_pkg::OP_RECORD) ? dlha_pkg::ST_REMOVE
                                                              : dlha_pkg::ST_REPLY;
            end else begin
               if (!hit_ff && match) begin
                  hit_in        = 1'b1;
                  hit_idx_in    = scan_idx;
                  hit_letter_in = letter_ff[scan_idx];
               end
               used_in = used_ff | (dlha_pkg::LETTER_SPACE'(1) << letter_ff[scan_idx]);
               idx_in  = idx_ff + CNT_W'(1);
            end
         end
         dlha_pkg::ST_REMOVE: begin
            do_remove = hit_ff || (CAP_W'(count_ff) >= cap);
            if (do_remove && count_ff != '0) begin
               count_in = count_ff - CNT_W'(1);
            end
            state_in = dlha_pkg::ST_APPEND;
         end
         dlha_pkg::ST_APPEND: begin
            if (CAP_W'(count_ff) < depth_ext) begin
               do_append = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end
            state_in = dlha_pkg::ST_REPLY;
         end
         dlha_pkg::ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (item_ff.op == dlha_pkg::OP_ASSIGN) begin
                  rsp_in = assign_result;
               end else begin
                  rsp_in.status = dlha_pkg::STATUS_OK;
                  rsp_in.letter = '0;
                  rsp_in.count  = dlha_pkg::COUNT_OUT_W'(count_ff);
               end
               state_in = dlha_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dlha_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlha_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      used_ff       <= used_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_letter_ff <= hit_letter_in;
      rsp_ff        <= rsp_in;
   end

   // Close the gap left by a removed entry, then write the newest entry at the tail.
   always_ff @(posedge clock) begin
      for (int j = 0; j < HISTORY_DEPTH - 1; j++) begin
         if (do_remove && IDX_W'(j) >= remove_idx && CNT_W'(j + 1) < count_ff) begin
            key_ff[j]    <= key_ff[j + 1];
            letter_ff[j] <= letter_ff[j + 1];
         end
      end
      if (do_append) begin
         key_ff[count_ff[IDX_W-1:0]]    <= item_ff.key;
         letter_ff[count_ff[IDX_W-1:0]] <= item_ff.mounted;
      end
   end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the drive letter history allocator.
`timescale 1ns / 100ps
module testbench;
   import dlha_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 190;
   localparam int PHASE_COUNT  = 8;
   localparam int POOL_SIZE    = 12;

   typedef struct {
      item_type   it;
      bit         typed;
      result_type want;
   } script_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // mirror of the block's history and registers
   unit_key_type            hist_key [HISTORY_DEPTH_DEF];
   logic [LETTER_W-1:0]     hist_letter [HISTORY_DEPTH_DEF];
   int                      hist_count;
   logic [LETTER_W-1:0]     cfg_first;
   logic [LETTER_W-1:0]     cfg_last;
   logic [LETTER_COUNT-1:0] cfg_forbid;
   logic [LIMIT_W-1:0]      cfg_limit;

   result_type              pending_replies[$];
   script_row_type          script[$];
   unit_key_type            unit_pool [POOL_SIZE];
   int                      mismatches;
   int                      quiet_cycles;
   int                      send_idle_pct;
   int                      rsp_stall_pct;

   drive_letter_history_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void drop_entry(input int k);
      for (int i = k; i + 1 < hist_count; i++) begin
         hist_key[i]    = hist_key[i + 1];
         hist_letter[i] = hist_letter[i + 1];
      end
      if (hist_count > 0) hist_count--;
   endfunction

   // Work out the reply to one transaction and advance the mirrored history.
   function automatic result_type allocate_or_record(input item_type it);
      result_type              r;
      logic [LETTER_COUNT-1:0] avail;
      logic [LETTER_COUNT-1:0] pick;
      logic [LETTER_SPACE-1:0] used;
      logic [LETTER_W-1:0]     h;
      int                      hit;
      int                      cap;
      r.status = STATUS_OK;
      r.letter = '0;
      hit = -1;
      for (int i = 0; i < hist_count; i++) begin
         if (hit < 0 && hist_key[i] == it.key) hit = i;
      end
      if (it.op == OP_ASSIGN) begin
         avail = '0;
         for (int i = 0; i < LETTER_COUNT; i++) begin
            if (i >= cfg_first && i <= cfg_last) avail[i] = 1'b1;
         end
         avail = avail & ~cfg_forbid & ~it.avail;
         if (avail == '0) begin
            r.status = STATUS_NO_LETTER;
         end else begin
            used = '0;
            for (int i = 0; i < hist_count; i++) used[hist_letter[i]] = 1'b1;
            // prefer a free letter that no remembered unit holds
            pick = avail & ~used[LETTER_COUNT-1:0];
            if (pick == '0) pick = avail;
            for (int i = LETTER_COUNT - 1; i >= 0; i--) begin
               if (pick[i]) r.letter = LETTER_W'(i);
            end
            if (hit >= 0) begin
               h = hist_letter[hit];
               if (h < LETTER_COUNT && avail[h]) r.letter = h;
            end
         end
      end else begin
         cap = (cfg_limit > HISTORY_DEPTH_DEF) ? HISTORY_DEPTH_DEF : int'(cfg_limit);
         if (cap != 0) begin
            if (hit >= 0) drop_entry(hit);
            else if (hist_count >= cap) drop_entry(0);
            hist_key[hist_count]    = it.key;
            hist_letter[hist_count] = it.mounted;
            hist_count++;
         end
      end
      r.count = COUNT_OUT_W'(hist_count);
      return r;
   endfunction

   function automatic unit_key_type random_key();
      logic [191:0] raw;
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      return raw[$bits(unit_key_type)-1:0];
   endfunction

   // Change one bit of one key field (whole vendor inverted if nothing changed): a near miss for the unit match.
   function automatic unit_key_type mutate_key(input unit_key_type k);
      unit_key_type r;
      r = k;
      case ($urandom_range(0, 6))
         0: r.vendor[$urandom_range(0, 15)]   = ~k.vendor[0];
         1: r.product[$urandom_range(0, 15)]  = ~r.product[0];
         2: r.rel[$urandom_range(0, 15)]      = ~r.rel[0];
         3: r.cfg_num = r.cfg_num ^ (8'd1 << $urandom_range(0, 7));
         4: r.iface_num = r.iface_num ^ (8'd1 << $urandom_range(0, 7));
         5: r.serial = r.serial ^ (64'd1 << $urandom_range(0, 63));
         default: r.otg = r.otg ^ (8'd1 << $urandom_range(0, 7));
      endcase
      if (r == k) r.vendor = ~k.vendor;
      return r;
   endfunction

   function automatic item_type make_item(input op_type op, input unit_key_type k,
                                          input logic [LETTER_W-1:0] m,
                                          input logic [LETTER_COUNT-1:0] p);
      item_type it;
      it.op      = op;
      it.key     = k;
      it.mounted = m;
      it.avail   = p;
      return it;
   endfunction

   task automatic add_row(input item_type it, input bit typed,
                          input status_type st = STATUS_OK,
                          input logic [LETTER_W-1:0] ltr = '0,
                          input logic [COUNT_OUT_W-1:0] cnt = '0);
      script_row_type row;
      row.it          = it;
      row.typed       = typed;
      row.want.status = st;
      row.want.letter = ltr;
      row.want.count  = cnt;
      script.push_back(row);
   endtask

   // Offer one transaction, hold it until accepted, then queue its reply.
   task automatic offer_request(input item_type it, input bit typed, input result_type want);
      result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {1'b0, it.avail, it.mounted, it.key.otg, it.key.serial, it.key.iface_num,
                     it.key.cfg_num, it.key.rel, it.key.product, it.key.vendor};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = allocate_or_record(it);
      pending_replies.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic drain_outstanding();
      while (pending_replies.size() != 0) @(negedge clock);
   endtask

   // Write all four registers back to back; psel drops once at the end.
   task automatic program_settings(input logic [31:0] first_v, input logic [31:0] last_v,
                                   input logic [31:0] forbid_v, input logic [31:0] limit_v);
      logic [31:0]   vals [4];
      csr_index_type idx;
      vals[CSR_RANGE_FIRST]    = first_v;
      vals[CSR_RANGE_LAST]     = last_v;
      vals[CSR_FORBIDDEN_MASK] = forbid_v;
      vals[CSR_HISTORY_LIMIT]  = limit_v;
      idx = idx.first();
      repeat (4) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {idx, 2'b00};
         csr_pwdata  <= vals[idx];
         @(negedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         @(negedge clock);
         idx = idx.next();
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg_first  = vals[CSR_RANGE_FIRST][LETTER_W-1:0];
      cfg_last   = vals[CSR_RANGE_LAST][LETTER_W-1:0];
      cfg_forbid = vals[CSR_FORBIDDEN_MASK][LETTER_COUNT-1:0];
      cfg_limit  = vals[CSR_HISTORY_LIMIT][LIMIT_W-1:0];
   endtask

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatches++;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : reply_monitor
      result_type got;
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser);
            got.letter = rsp_tdata[4:0];
            got.count  = rsp_tdata[8:5];
            if (pending_replies.size() == 0) begin
               $display("%0t: unexpected reply, got status %0h letter %0d count %0d",
                        $time, got.status, got.letter, got.count);
               mismatches++;
            end else begin
               want = pending_replies.pop_front();
               if (got.status !== want.status) report_field("status", want.status, got.status);
               if (got.letter !== want.letter) report_field("drive_letter", want.letter,
                                                            got.letter);
               if (got.count !== want.count) report_field("history_count", want.count,
                                                          got.count);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      item_type                it;
      unit_key_type            key_zero;
      unit_key_type            key_ones;
      unit_key_type            key_a;
      unit_key_type            key_b;
      unit_key_type            k;
      int                      roll;
      logic [31:0]             first_v;
      logic [31:0]             last_v;
      logic [31:0]             forbid_v;
      logic [31:0]             limit_v;
      logic [LETTER_COUNT-1:0] present;
      logic [LETTER_W-1:0]     mounted;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      rsp_tready    = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      mismatches    = 0;
      quiet_cycles  = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hist_count    = 0;
      cfg_first     = 5'd0;
      cfg_last      = 5'd25;
      cfg_forbid    = '0;
      cfg_limit     = 4'd8;

      for (int j = 0; j < POOL_SIZE; j++) begin
         unit_pool[j] = (j % 3 == 2) ? mutate_key(unit_pool[j - 1]) : random_key();
      end
      key_zero = '0;
      key_ones = '1;
      key_a    = random_key();
      key_b    = key_a;
      key_b.otg = ~key_a.otg;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, reset register values
      add_row(make_item(OP_ASSIGN, key_ones, 5'd0, '1), 1'b1, STATUS_NO_LETTER, 5'd0, 4'd0);
      add_row(make_item(OP_ASSIGN, key_zero, 5'd0, '0), 1'b1, STATUS_OK, 5'd0, 4'd0);
      add_row(make_item(OP_ASSIGN, key_ones, 5'd31, 26'h1FF_FFFF), 1'b1, STATUS_OK, 5'd25, 4'd0);
      add_row(make_item(OP_RECORD, key_ones, 5'd25, '1), 1'b1, STATUS_OK, 5'd0, 4'd1);
      add_row(make_item(OP_ASSIGN, key_ones, 5'd0, '0), 1'b0);
      add_row(make_item(OP_ASSIGN, key_zero, 5'd0, '0), 1'b0);
      add_row(make_item(OP_RECORD, key_zero, 5'd0, '0), 1'b0);
      add_row(make_item(OP_ASSIGN, key_a, 5'd0, '0), 1'b0);
      // remembered letter taken: fall back to lowest unused
      add_row(make_item(OP_ASSIGN, key_ones, 5'd0, 26'h200_0000), 1'b0);
      add_row(make_item(OP_RECORD, key_ones, 5'd3, '0), 1'b0);
      // letter beyond the alphabet stored as given
      add_row(make_item(OP_RECORD, key_a, 5'd31, '0), 1'b0);
      add_row(make_item(OP_ASSIGN, key_a, 5'd0, '0), 1'b0);
      // only a remembered letter is left free
      add_row(make_item(OP_ASSIGN, key_b, 5'd0, ~26'h000_0008), 1'b0);
      for (int i = 0; i < 8; i++) begin
         k = key_a;
         k.vendor = 16'(i + 100);
         add_row(make_item(OP_RECORD, k, 5'(i + 4), '0), 1'b0);
      end
      add_row(make_item(OP_ASSIGN, key_zero, 5'd0, '0), 1'b0);
      add_row(make_item(OP_RECORD, key_b, 5'd0, 26'h155_5555), 1'b0);
      add_row(make_item(OP_ASSIGN, key_b, 5'd0, 26'h2AA_AAAA), 1'b0);
      foreach (script[n]) offer_request(script[n].it, script[n].typed, script[n].want);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // drop valid first so the last transaction is not taken twice
         req_tvalid <= 1'b0;
         drain_outstanding();
         case (phase)
            1: begin
               first_v = 3; last_v = 10; forbid_v = $urandom() & 32'h3FF_FFFF; limit_v = 4;
            end
            2: begin
               // inverted range, everything forbidden, limit above depth
               first_v = 20; last_v = 5; forbid_v = 32'h3FF_FFFF; limit_v = 15;
            end
            3: begin
               // limit below the current count
               first_v = 0; last_v = 31; forbid_v = $urandom() & $urandom() & 32'h3FF_FFFF;
               limit_v = 2;
            end
            4: begin
               first_v = 0; last_v = 25; forbid_v = 0; limit_v = 0;
            end
            5: begin
               first_v = 25; last_v = 25; forbid_v = 0; limit_v = 8;
            end
            6: begin
               first_v = $urandom_range(0, 31); last_v = $urandom_range(0, 31);
               forbid_v = $urandom() & $urandom() & 32'h3FF_FFFF;
               limit_v = $urandom_range(0, 15);
            end
            default: begin
               first_v = 0; last_v = 25; forbid_v = 0; limit_v = 8;
            end
         endcase
         @(negedge clock);
         program_settings(first_v, last_v, forbid_v, limit_v);
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 54; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 54; end
            default: begin send_idle_pct = 32; rsp_stall_pct = 32; end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) k = unit_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (roll < 92) k = mutate_key(unit_pool[$urandom_range(0, POOL_SIZE - 1)]);
            else k = random_key();
            mounted = ($urandom_range(0, 99) < 5) ? 5'($urandom_range(26, 31))
                                                  : 5'($urandom_range(0, 25));
            case ($urandom_range(0, 7))
               0: present = '0;
               1: present = '1;
               2, 3: present = $urandom() & $urandom() & $urandom();
               4: present = $urandom() | $urandom();
               default: present = $urandom();
            endcase
            it = make_item(($urandom_range(0, 99) < 30) ? OP_RECORD : OP_ASSIGN,
                           k, mounted, present);
            offer_request(it, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      drain_outstanding();
      repeat (16) @(negedge clock);
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
